// File: rtl/wuia_pkg.sv
// Shared types and constants for the wide unsigned integer ALU.
// No dependencies.
package wuia_pkg;
  localparam logic [2:0] MODE_CMP = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_SUB = 3'd2;
  localparam logic [2:0] MODE_MUL = 3'd3;
  localparam logic [2:0] MODE_DIV = 3'd4;

  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_GT = 2'd1;
  localparam logic [1:0] ORD_LT = 2'd2;

  typedef struct packed {
    logic load;    // capture operands, start op
    logic step;    // one iteration of mul/div
    logic finish;  // form result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic iterative; // captured op needs mul/div iterations
    logic last;      // current step is the final one
  } dp_sts_t;
endpackage

// File: rtl/wuia_datapath.sv
// Datapath: operand registers, shift-add multiplier, restoring divider, result regs.
// Depends on wuia_pkg.
module wuia_datapath #(
  parameter int W = 128
) (
  input  logic               clk,
  input  wuia_pkg::dp_cmd_t  cmd,
  output wuia_pkg::dp_sts_t  sts,
  input  logic [2:0]         in_mode,
  input  logic [127:0]       in_a,
  input  logic [127:0]       in_b,
  output logic [127:0]       res,
  output logic [127:0]       rem,
  output logic [1:0]         ord,
  output logic               dz
);
  localparam int CW = $clog2(W + 1);

  logic [2:0]   mode_r;
  logic [W-1:0] a_r, b_r, acc_r, acc_nxt, rr_r, rr_nxt, sh_r, sh_nxt;
  logic [CW-1:0] cnt_r;
  logic [127:0] res_r, rem_r, res_nxt, rem_nxt;
  logic [1:0]   ord_r, ord_nxt;
  logic         dz_r, dz_nxt;
  logic [W:0]   trial;
  logic [W-1:0] rsh;
  logic [W-1:0] sum_w, dif_w;

  assign sts.iterative = (mode_r == wuia_pkg::MODE_MUL) ||
                         (mode_r == wuia_pkg::MODE_DIV && b_r != '0);
  assign sts.last = (cnt_r == CW'(1));

  // divider: shift in next dividend bit (sh_r msb), trial subtract
  assign rsh   = {rr_r[W-2:0], sh_r[W-1]};
  assign trial = {rr_r[W-1], rsh} - {1'b0, b_r};

  assign sum_w = a_r + b_r;
  assign dif_w = a_r - b_r;

  always_comb begin
    acc_nxt = acc_r;
    rr_nxt  = rr_r;
    sh_nxt  = {sh_r[W-2:0], 1'b0};
    if (mode_r == wuia_pkg::MODE_MUL) begin
      // sh_r holds multiplier, consume msb first
      acc_nxt = {acc_r[W-2:0], 1'b0} + (sh_r[W-1] ? a_r : '0);
    end else begin
      acc_nxt = {acc_r[W-2:0], ~trial[W]};
      rr_nxt  = trial[W] ? rsh : trial[W-1:0];
    end
  end

  always_comb begin
    res_nxt = '0;
    rem_nxt = '0;
    ord_nxt = wuia_pkg::ORD_EQ;
    dz_nxt  = 1'b0;
    unique case (mode_r)
      wuia_pkg::MODE_CMP:
        ord_nxt = (a_r == b_r) ? wuia_pkg::ORD_EQ :
                  (a_r > b_r) ? wuia_pkg::ORD_GT : wuia_pkg::ORD_LT;
      wuia_pkg::MODE_ADD: res_nxt = 128'(sum_w);
      wuia_pkg::MODE_SUB: res_nxt = 128'(dif_w);
      wuia_pkg::MODE_MUL: res_nxt = 128'(acc_r);
      wuia_pkg::MODE_DIV: begin
        if (b_r == '0) dz_nxt = 1'b1;
        else begin
          res_nxt = 128'(acc_r);
          rem_nxt = 128'(rr_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      a_r    <= in_a[W-1:0];
      b_r    <= in_b[W-1:0];
      acc_r  <= '0;
      rr_r   <= '0;
      sh_r   <= (in_mode == wuia_pkg::MODE_MUL) ? in_b[W-1:0] : in_a[W-1:0];
      cnt_r  <= CW'(W);
    end else if (cmd.step) begin
      acc_r <= acc_nxt;
      rr_r  <= rr_nxt;
      sh_r  <= sh_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.finish) begin
      res_r <= res_nxt;
      rem_r <= rem_nxt;
      ord_r <= ord_nxt;
      dz_r  <= dz_nxt;
    end
  end

  assign res = res_r;
  assign rem = rem_r;
  assign ord = ord_r;
  assign dz  = dz_r;
endmodule

// File: rtl/wuia_ctrl.sv
// Controller FSM: sequences load, iterate and finish; owns handshake state.
// Depends on wuia_pkg.
module wuia_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output wuia_pkg::dp_cmd_t  cmd,
  input  wuia_pkg::dp_sts_t  sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       free;

  assign free      = !ovld_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt  = state_r;
    ovld_nxt   = ovld_r && out_stall;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: state_nxt = sts.iterative ? S_RUN : S_DONE;
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) state_nxt = S_DONE;
      end
      S_DONE: if (free) begin
        cmd.finish = 1'b1;
        ovld_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end
endmodule

// File: rtl/wide_unsigned_integer_alu.sv
// Top level of the wide unsigned integer ALU: controller plus datapath.
// Depends on wuia_pkg, wuia_ctrl, wuia_datapath.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | mode, a_low/high, b_low/high
//  out     | output    | out_valid/out_stall| result, remainder, order, flag
//
// Compare/add/subtract/divide-by-zero: each word passes through states IDLE, DEC, DONE.
// Multiply and divide also pass through RUN between DEC and DONE, one bit per cycle in the datapath.
// Reset is synchronous, active low; no clearing pass.
// The result register holds while out_stall; the next word may be taken and computed
// meanwhile, but its result is written only once the held word is handed over.
module wide_unsigned_integer_alu #(
  parameter int OPERAND_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [63:0] in_b_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high,
  output logic [63:0] out_remainder_low,
  output logic [63:0] out_remainder_high,
  output logic [1:0]  out_order,
  output logic        out_divide_by_zero
);
  localparam int W = 8 * OPERAND_BYTES;

  wuia_pkg::dp_cmd_t cmd;
  wuia_pkg::dp_sts_t sts;
  logic [127:0] res, rem;

  wuia_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  wuia_datapath #(.W(W)) u_dp (
    .clk, .cmd, .sts, .in_mode,
    .in_a({in_a_high, in_a_low}),
    .in_b({in_b_high, in_b_low}),
    .res, .rem, .ord(out_order), .dz(out_divide_by_zero)
  );

  assign out_result_low     = res[63:0];
  assign out_result_high    = res[127:64];
  assign out_remainder_low  = rem[63:0];
  assign out_remainder_high = rem[127:64];
endmodule

// File: rtl/wuia_checker.sv
// Port-level checker for wide_unsigned_integer_alu, bound to the top level.
// Depends on wuia_pkg.
module wuia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_low,
  input logic [63:0] out_remainder_low,
  input logic [63:0] out_remainder_high,
  input logic [1:0]  out_order,
  input logic        out_divide_by_zero
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("accept not followed by busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_low)))
    else $error("stalled word changed");
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_order == wuia_pkg::ORD_EQ || out_order == wuia_pkg::ORD_GT ||
                   out_order == wuia_pkg::ORD_LT)) else $error("bad order code");
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_remainder_low == '0 && out_remainder_high == '0 &&
       out_order == wuia_pkg::ORD_EQ))
    else $error("divide by zero word not clean");
  a_no_out_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid)) else $error("early word");
endmodule

bind wide_unsigned_integer_alu wuia_checker u_wuia_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_result_low, .out_remainder_low, .out_remainder_high,
  .out_order, .out_divide_by_zero
);
